FILE: hw/rtl/keypad_frequency_entry_core_macros.svh
// assertion macros for the keypad frequency entry core
`ifndef KEYPAD_FREQUENCY_ENTRY_CORE_MACROS_SVH
`define KEYPAD_FREQUENCY_ENTRY_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define KFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define KFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/kfe_pkg.sv
`default_nettype none

package kfe_pkg;

  localparam int MAX_CHARS = 7;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int IDX_W     = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int FRAC_W    = 10;
  localparam int FREQ_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [FREQ_W-1:0] LOW_RESET  = 32'd400000;
  localparam logic [FREQ_W-1:0] HIGH_RESET = 32'd450000;

  localparam logic [3:0] KEY_DIGIT_LO = 4'd0;
  localparam logic [3:0] KEY_DIGIT_HI = 4'd9;
  localparam logic [3:0] KEY_A        = 4'd10;
  localparam logic [3:0] KEY_B        = 4'd11;
  localparam logic [3:0] KEY_C        = 4'd12;
  localparam logic [3:0] KEY_D        = 4'd13;
  localparam logic [3:0] KEY_STAR     = 4'd14;
  localparam logic [3:0] KEY_HASH     = 4'd15;
  localparam logic [3:0] POINT_CODE   = 4'd10;

  localparam logic REG_IDX_LOW  = 1'b0;
  localparam logic REG_IDX_HIGH = 1'b1;

  typedef enum logic [2:0] {
    EV_IGNORED   = 3'd0,
    EV_TOGGLED   = 3'd1,
    EV_STARTED   = 3'd2,
    EV_APPENDED  = 3'd3,
    EV_REMOVED   = 3'd4,
    EV_ACCEPTED  = 3'd5,
    EV_RANGE     = 3'd6,
    EV_CANCELLED = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PARSE,
    S_PAD,
    S_SCALE,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic   toggle;
    logic   start;
    logic   append;
    logic   append_point;
    logic   remove;
    logic   leave;
    logic   parse_start;
    logic   parse_step;
    logic   pad_step;
    logic   scale;
    logic   load_out;
    logic   check;
    event_t ev;
  } cmd_t;

  typedef struct packed {
    logic entry;
    logic empty;
    logic full;
    logic parse_last;
    logic frac_full;
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kfe_datapath.sv
`default_nettype none

module kfe_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [3:0]                  key_code,
  input  wire logic [kfe_pkg::FREQ_W-1:0]  low_khz,
  input  wire logic [kfe_pkg::FREQ_W-1:0]  high_khz,
  input  wire kfe_pkg::cmd_t               cmd,
  output kfe_pkg::status_t                 status,
  output logic [2:0]                       event_res,
  output logic [kfe_pkg::FREQ_W-1:0]       parsed_khz,
  output logic                             frame_mode,
  output logic                             entry_active,
  output logic [2:0]                       entry_length
);

  logic                         entry_r, entry_nxt;
  logic                         frame_r, frame_nxt;
  logic [kfe_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [3:0]                   chars_r [kfe_pkg::MAX_CHARS];
  logic [kfe_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [kfe_pkg::FREQ_W-1:0]   ip_r, ip_nxt;
  logic [kfe_pkg::FRAC_W-1:0]   fp_r, fp_nxt;
  logic [1:0]                   nfrac_r, nfrac_nxt;
  logic                         seen_r, seen_nxt;
  logic [kfe_pkg::FREQ_W-1:0]   prod_r, prod_nxt;
  logic [2:0]                   ev_r, ev_nxt;
  logic [kfe_pkg::FREQ_W-1:0]   freq_r, freq_nxt;
  logic                         oframe_r, oentry_r;
  logic [2:0]                   olen_r;
  logic [3:0]                   cur_char;
  logic [3:0]                   app_code;
  logic [kfe_pkg::FREQ_W-1:0]   sum;
  logic                         in_range;

  assign cur_char = chars_r[idx_r];
  assign app_code = cmd.append_point ? kfe_pkg::POINT_CODE : key_code;
  assign sum      = prod_r + kfe_pkg::FREQ_W'(fp_r);
  assign in_range = (sum >= low_khz) && (sum <= high_khz);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.start) begin
      entry_nxt = 1'b1;
    end else if (cmd.leave) begin
      entry_nxt = 1'b0;
    end
    frame_nxt = frame_r ^ cmd.toggle;
    count_nxt = count_r;
    if (cmd.start) begin
      count_nxt = '0;
    end else if (cmd.append) begin
      count_nxt = count_r + kfe_pkg::CNT_W'(1);
    end else if (cmd.remove) begin
      count_nxt = count_r - kfe_pkg::CNT_W'(1);
    end
  end

  // parse loop, one stored character a cycle, then fraction padding
  always_comb begin
    idx_nxt   = idx_r;
    ip_nxt    = ip_r;
    fp_nxt    = fp_r;
    nfrac_nxt = nfrac_r;
    seen_nxt  = seen_r;
    prod_nxt  = prod_r;
    if (cmd.parse_start) begin
      idx_nxt   = '0;
      ip_nxt    = '0;
      fp_nxt    = '0;
      nfrac_nxt = '0;
      seen_nxt  = 1'b0;
    end else if (cmd.parse_step) begin
      idx_nxt = idx_r + kfe_pkg::IDX_W'(1);
      if (cur_char == kfe_pkg::POINT_CODE) begin
        seen_nxt = 1'b1;
      end else if (seen_r) begin
        if (nfrac_r != 2'd3) begin
          fp_nxt    = kfe_pkg::FRAC_W'(fp_r * kfe_pkg::FRAC_W'(10))
                      + kfe_pkg::FRAC_W'(cur_char);
          nfrac_nxt = nfrac_r + 2'd1;
        end
      end else begin
        ip_nxt = kfe_pkg::FREQ_W'(ip_r * kfe_pkg::FREQ_W'(10))
                 + kfe_pkg::FREQ_W'(cur_char);
      end
    end else if (cmd.pad_step) begin
      fp_nxt    = kfe_pkg::FRAC_W'(fp_r * kfe_pkg::FRAC_W'(10));
      nfrac_nxt = nfrac_r + 2'd1;
    end
    if (cmd.scale) begin
      prod_nxt = kfe_pkg::FREQ_W'(ip_r * kfe_pkg::FREQ_W'(1000));
    end
  end

  always_comb begin
    ev_nxt   = 3'(cmd.ev);
    freq_nxt = '0;
    if (cmd.check) begin
      ev_nxt   = in_range ? 3'(kfe_pkg::EV_ACCEPTED) : 3'(kfe_pkg::EV_RANGE);
      freq_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= 1'b0;
      frame_r <= 1'b0;
      count_r <= '0;
    end else begin
      entry_r <= entry_nxt;
      frame_r <= frame_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      chars_r[count_r[kfe_pkg::IDX_W-1:0]] <= app_code;
    end
    idx_r   <= idx_nxt;
    ip_r    <= ip_nxt;
    fp_r    <= fp_nxt;
    nfrac_r <= nfrac_nxt;
    seen_r  <= seen_nxt;
    prod_r  <= prod_nxt;
    if (cmd.load_out) begin
      ev_r     <= ev_nxt;
      freq_r   <= freq_nxt;
      oframe_r <= frame_nxt;
      oentry_r <= entry_nxt;
      olen_r   <= 3'(count_nxt);
    end
  end

  assign status.entry      = entry_r;
  assign status.empty      = (count_r == '0);
  assign status.full       = (count_r >= kfe_pkg::CNT_W'(kfe_pkg::MAX_CHARS));
  assign status.parse_last = ((kfe_pkg::CNT_W'(idx_r) + kfe_pkg::CNT_W'(1)) == count_r);
  assign status.frac_full  = (nfrac_r == 2'd3);

  assign event_res    = ev_r;
  assign parsed_khz   = freq_r;
  assign frame_mode   = oframe_r;
  assign entry_active = oentry_r;
  assign entry_length = olen_r;

endmodule

`default_nettype wire

FILE: hw/rtl/kfe_ctrl.sv
`default_nettype none

`include "keypad_frequency_entry_core_macros.svh"

module kfe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [3:0]        in_key_code,
  input  wire logic              in_tx_busy,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire kfe_pkg::status_t  status,
  output kfe_pkg::cmd_t          cmd
);

  kfe_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            acc;

  assign in_stall = !((state_r == kfe_pkg::S_IDLE) && (!out_valid_r || !out_stall));
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.ev    = kfe_pkg::EV_IGNORED;
    case (state_r)
      kfe_pkg::S_IDLE: begin
        if (acc) begin
          if (!in_tx_busy) begin
            if (!status.entry) begin
              case (in_key_code) inside
                kfe_pkg::KEY_C: begin
                  cmd.toggle = 1'b1;
                  cmd.ev     = kfe_pkg::EV_TOGGLED;
                end
                kfe_pkg::KEY_A: begin
                  cmd.start = 1'b1;
                  cmd.ev    = kfe_pkg::EV_STARTED;
                end
                default: ;
              endcase
            end else begin
              case (in_key_code) inside
                [kfe_pkg::KEY_DIGIT_LO:kfe_pkg::KEY_DIGIT_HI], kfe_pkg::KEY_B: begin
                  if (!status.full) begin
                    cmd.append       = 1'b1;
                    cmd.append_point = (in_key_code == kfe_pkg::KEY_B);
                    cmd.ev           = kfe_pkg::EV_APPENDED;
                  end
                end
                kfe_pkg::KEY_STAR: begin
                  if (!status.empty) begin
                    cmd.remove = 1'b1;
                    cmd.ev     = kfe_pkg::EV_REMOVED;
                  end
                end
                kfe_pkg::KEY_HASH: begin
                  if (!status.empty) begin
                    cmd.parse_start = 1'b1;
                    state_nxt       = kfe_pkg::S_PARSE;
                  end
                end
                kfe_pkg::KEY_D: begin
                  cmd.leave = 1'b1;
                  cmd.ev    = kfe_pkg::EV_CANCELLED;
                end
                default: ;
              endcase
            end
          end
          cmd.load_out = !cmd.parse_start;
        end
      end
      kfe_pkg::S_PARSE: begin
        cmd.parse_step = 1'b1;
        if (status.parse_last) begin
          state_nxt = kfe_pkg::S_PAD;
        end
      end
      kfe_pkg::S_PAD: begin
        if (status.frac_full) begin
          state_nxt = kfe_pkg::S_SCALE;
        end else begin
          cmd.pad_step = 1'b1;
        end
      end
      kfe_pkg::S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = kfe_pkg::S_CHECK;
      end
      kfe_pkg::S_CHECK: begin
        // hold the parsed value until the result slot is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          cmd.check    = 1'b1;
          cmd.leave    = 1'b1;
          state_nxt    = kfe_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kfe_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kfe_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `KFE_ASSERT_NOW(a_no_overwrite, cmd.load_out, !(out_valid_r && out_stall), "result beat overwritten while held")
  `KFE_ASSERT_NEXT(a_hash_parses, acc && !in_tx_busy && status.entry && !status.empty && (in_key_code == kfe_pkg::KEY_HASH), state_r == kfe_pkg::S_PARSE, "confirm did not start parse")
  `KFE_ASSERT_NEXT(a_check_delivers, (state_r == kfe_pkg::S_CHECK) && cmd.load_out, out_valid_r && (state_r == kfe_pkg::S_IDLE), "parse result not presented")

endmodule

`default_nettype wire

FILE: hw/rtl/keypad_frequency_entry_core.sv
// a key's result beat comes in the cycle after it, except confirm with a non-empty buffer
// confirm: parses each stored character, pads the fraction to 3 digits, scales, then checks
// a confirm result also waits while the previous result beat is still stalled
// throughput: one key beat a cycle when idle and results are taken; parse walks a character a cycle
// reset clears entry mode, frame type, buffer length and the result beat; limits 400000/450000 khz
// buffer characters are not cleared by reset
`default_nettype none

module keypad_frequency_entry_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [kfe_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [kfe_pkg::DATA_W-1:0]  pwdata,
  output logic      [kfe_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [3:0]                  in_key_code,
  input  wire logic                        in_tx_busy,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [2:0]                  out_event_res,
  output logic      [kfe_pkg::FREQ_W-1:0]  out_parsed_khz,
  output logic                             out_frame_mode,
  output logic                             out_entry_active,
  output logic      [2:0]                  out_entry_length
);

  logic [kfe_pkg::FREQ_W-1:0] low_r, low_nxt;
  logic [kfe_pkg::FREQ_W-1:0] high_r, high_nxt;
  logic                       wr_en;
  logic                       reg_idx;
  kfe_pkg::cmd_t              cmd;
  kfe_pkg::status_t           status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (wr_en) begin
      case (reg_idx)
        kfe_pkg::REG_IDX_LOW:  low_nxt  = pwdata;
        kfe_pkg::REG_IDX_HIGH: high_nxt = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= kfe_pkg::LOW_RESET;
      high_r <= kfe_pkg::HIGH_RESET;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  assign prdata = (reg_idx == kfe_pkg::REG_IDX_HIGH) ? high_r : low_r;

  kfe_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_key_code (in_key_code),
    .in_tx_busy  (in_tx_busy),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .cmd         (cmd)
  );

  kfe_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .key_code     (in_key_code),
    .low_khz      (low_r),
    .high_khz     (high_r),
    .cmd          (cmd),
    .status       (status),
    .event_res    (out_event_res),
    .parsed_khz   (out_parsed_khz),
    .frame_mode   (out_frame_mode),
    .entry_active (out_entry_active),
    .entry_length (out_entry_length)
  );

endmodule

`default_nettype wire
